FILE: sv/hcd_pkg.sv
// Shared types and constants for the chunked transfer decoder.
// Used by the front classifier, the back sequencer, the top level and the testbench.
`default_nettype none

package hcd_pkg;

	localparam logic [31:0] RESET_LIMIT = 32'd2097152;

	localparam logic [7:0] CH_CR   = 8'd13;
	localparam logic [7:0] CH_LF   = 8'd10;
	localparam logic [7:0] CH_SEMI = 8'd59;

	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_COMPLETE = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;

	localparam logic [1:0] ERR_BAD_SIZE   = 2'd0;
	localparam logic [1:0] ERR_BAD_ENDING = 2'd1;
	localparam logic [1:0] ERR_TOO_LARGE  = 2'd2;
	localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

	typedef enum logic [3:0] {
		PH_SIZE,
		PH_EXT,
		PH_BAD,
		PH_DATA,
		PH_END1,
		PH_END2,
		PH_END2_BAD,
		PH_TRAILER,
		PH_DONE,
		PH_ERROR
	} phase_t;

	// A received byte after classification.
	typedef struct packed {
		logic       eos;
		logic       is_cr;
		logic       is_lf;
		logic       is_semi;
		logic       is_hex;
		logic [3:0] hex_val;
		logic [7:0] data;
	} cls_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic [1:0] error_code;
	} res_t;

endpackage

`default_nettype wire

FILE: sv/hcd_queue.sv
// Small first-in first-out queue of fixed-width words held in registers.
// Stands between the decoder stages; depends on nothing else.
`default_nettype none

module hcd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/hcd_front.sv
// Input stage: accepts body bytes, classifies them and registers the result.
// Depends on hcd_pkg for the classified item type and character constants.
`default_nettype none

module hcd_front
	import hcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic [7:0] stream_byte,
	input  wire logic end_of_stream,
	output logic      full,
	output logic      item_valid,
	output cls_t      item,
	input  wire logic item_full
);

	logic valid_s1;
	cls_t item_s1;
	cls_t cls;
	logic load;

	always_comb begin
		cls         = '0;
		cls.eos     = end_of_stream;
		cls.data    = stream_byte;
		cls.is_cr   = (stream_byte == CH_CR);
		cls.is_lf   = (stream_byte == CH_LF);
		cls.is_semi = (stream_byte == CH_SEMI);
		if (stream_byte inside {[8'h30:8'h39]}) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = stream_byte[3:0];
		end else if (stream_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			// Letters a-f and A-F share the low three bits: 1..6 maps to 10..15.
			cls.is_hex  = 1'b1;
			cls.hex_val = 4'(stream_byte[2:0] + 4'd9);
		end
	end

	assign full       = valid_s1 && item_full;
	assign load       = push && !full;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (!item_full) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: sv/hcd_back.sv
// Chunk framing sequencer: consumes classified bytes and produces results.
// Depends on hcd_pkg; holds the size limit register and all framing state.
`default_nettype none

module hcd_back
	import hcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        size_limit_we,
	input  wire logic [31:0] size_limit_wdata,
	input  wire logic        item_valid,
	input  wire cls_t        item,
	output logic             item_pop,
	input  wire logic        res_full,
	output logic             res_push,
	output res_t             res
);

	phase_t      phase_q,  phase_n;
	logic [31:0] acc_q,    acc_n;
	logic [31:0] rem_q,    rem_n;
	logic [32:0] off_q,    off_n;
	logic        saw_q,    saw_n;
	logic        pcr_q,    pcr_n;
	logic        tle_q,    tle_n;
	logic [31:0] limit_q;

	logic        take;
	logic [35:0] acc_x16;
	logic [34:0] bound;

	assign take     = item_valid && !res_full;
	assign item_pop = take;
	assign acc_x16  = {acc_q, 4'b0000} + {32'd0, item.hex_val};
	// Offset after this byte plus size plus the closing CR LF.
	assign bound    = {2'b00, off_q} + {3'b000, acc_q} + 35'd3;

	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		rem_n    = rem_q;
		off_n    = off_q;
		saw_n    = saw_q;
		pcr_n    = pcr_q;
		tle_n    = tle_q;
		res_push = 1'b0;
		res      = '0;

		if (phase_q == PH_DONE || phase_q == PH_ERROR) begin
			phase_n = phase_q;
		end else if (item.eos) begin
			phase_n        = PH_ERROR;
			res_push       = 1'b1;
			res.kind       = KIND_ERROR;
			res.error_code = ERR_TRUNCATED;
		end else if (off_q >= {1'b0, limit_q}) begin
			// This byte pushes the body offset past the limit.
			off_n          = off_q + 1'b1;
			phase_n        = PH_ERROR;
			res_push       = 1'b1;
			res.kind       = KIND_ERROR;
			res.error_code = ERR_TOO_LARGE;
		end else begin
			off_n = off_q + 1'b1;
			case (phase_q)
				PH_SIZE, PH_EXT: begin
					if (pcr_q && item.is_lf) begin
						// End of a size line.
						pcr_n = 1'b0;
						if (!saw_q) begin
							phase_n        = PH_ERROR;
							res_push       = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_BAD_SIZE;
						end else if (acc_q == '0) begin
							phase_n = PH_TRAILER;
							tle_n   = 1'b1;
						end else if (bound > {3'b000, limit_q}) begin
							phase_n        = PH_ERROR;
							res_push       = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_TOO_LARGE;
						end else begin
							rem_n   = acc_q;
							phase_n = PH_DATA;
						end
					end else if (phase_q == PH_EXT) begin
						pcr_n = item.is_cr;
					end else if (pcr_q) begin
						phase_n = PH_BAD;
						pcr_n   = item.is_cr;
					end else if (item.is_cr) begin
						pcr_n = 1'b1;
					end else if (item.is_semi) begin
						phase_n = PH_EXT;
					end else if (!item.is_hex || acc_x16 > {4'd0, limit_q}) begin
						phase_n = PH_BAD;
					end else begin
						acc_n = acc_x16[31:0];
						saw_n = 1'b1;
					end
				end
				PH_BAD: begin
					if (pcr_q && item.is_lf) begin
						pcr_n          = 1'b0;
						phase_n        = PH_ERROR;
						res_push       = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_BAD_SIZE;
					end else begin
						pcr_n = item.is_cr;
					end
				end
				PH_DATA: begin
					rem_n            = rem_q - 1'b1;
					if (rem_q == 32'd1) begin
						phase_n = PH_END1;
					end
					res_push         = 1'b1;
					res.kind         = KIND_PAYLOAD;
					res.payload_byte = item.data;
				end
				PH_END1: begin
					phase_n = item.is_cr ? PH_END2 : PH_END2_BAD;
				end
				PH_END2: begin
					if (!item.is_lf) begin
						phase_n        = PH_ERROR;
						res_push       = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_BAD_ENDING;
					end else begin
						phase_n = PH_SIZE;
						acc_n   = '0;
						saw_n   = 1'b0;
						pcr_n   = 1'b0;
					end
				end
				PH_END2_BAD: begin
					phase_n        = PH_ERROR;
					res_push       = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_BAD_ENDING;
				end
				PH_TRAILER: begin
					if (pcr_q && item.is_lf) begin
						pcr_n = 1'b0;
						if (tle_q) begin
							phase_n  = PH_DONE;
							res_push = 1'b1;
							res.kind = KIND_COMPLETE;
						end else begin
							tle_n = 1'b1;
						end
					end else begin
						// A CR not followed by LF makes the line non-empty.
						pcr_n = item.is_cr;
						if (pcr_q || !item.is_cr) begin
							tle_n = 1'b0;
						end
					end
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end

		if (!take) begin
			res_push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= RESET_LIMIT;
		end else if (size_limit_we) begin
			limit_q <= size_limit_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			acc_q   <= '0;
			rem_q   <= '0;
			off_q   <= '0;
			saw_q   <= 1'b0;
			pcr_q   <= 1'b0;
			tle_q   <= 1'b1;
		end else if (take) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			rem_q   <= rem_n;
			off_q   <= off_n;
			saw_q   <= saw_n;
			pcr_q   <= pcr_n;
			tle_q   <= tle_n;
		end
	end

endmodule

`default_nettype wire

FILE: sv/http_chunked_decoder.sv
// HTTP chunked transfer decoder. Accepts one body byte per cycle unless back-pressured.
// A result reaches the output ports after its byte is registered by the input classifier
// and held in the internal queue; the sequencer decides in the cycle the item leaves that
// queue and writes the result queue at the end of it.
// The sequencer updates framing state once per cycle unless stalled; that sets the rate.
// arst_n clears both queues, returns the limit to 2097152 and starts at a size line.
`default_nettype none

module http_chunked_decoder
	import hcd_pkg::*;
#(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        size_limit_we,
	input  wire logic [31:0] size_limit_wdata,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  stream_byte,
	input  wire logic        end_of_stream,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [7:0]       payload_byte,
	output logic [1:0]       error_code
);

	logic front_valid;
	cls_t front_item;
	logic mid_full;
	logic mid_empty;
	cls_t mid_item;
	logic mid_pop;
	logic res_full;
	logic res_push;
	res_t res;
	res_t out_res;

	hcd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.stream_byte  (stream_byte),
		.end_of_stream(end_of_stream),
		.full         (full),
		.item_valid   (front_valid),
		.item         (front_item),
		.item_full    (mid_full)
	);

	hcd_queue #(
		.WIDTH($bits(cls_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_valid),
		.push_data(front_item),
		.full     (mid_full),
		.pop      (mid_pop),
		.pop_data (mid_item),
		.empty    (mid_empty)
	);

	hcd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.size_limit_we   (size_limit_we),
		.size_limit_wdata(size_limit_wdata),
		.item_valid      (!mid_empty),
		.item            (mid_item),
		.item_pop        (mid_pop),
		.res_full        (res_full),
		.res_push        (res_push),
		.res             (res)
	);

	hcd_queue #(
		.WIDTH($bits(res_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_data(res),
		.full     (res_full),
		.pop      (pop),
		.pop_data (out_res),
		.empty    (empty)
	);

	assign kind         = out_res.kind;
	assign payload_byte = out_res.payload_byte;
	assign error_code   = out_res.error_code;

endmodule

`default_nettype wire

FILE: tb/http_chunked_decoder_test.sv
// Self-checking testbench for the HTTP chunked transfer decoder (http_chunked_decoder).
// Drives framed body streams through the byte queue and checks every result against a
// predictor of the framing logic. Depends on hcd_pkg for the result type and the codes.
module http_chunked_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hcd_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;
	localparam int MAX_REPORTS = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        size_limit_we = 1'b0;
	logic [31:0] size_limit_wdata = '0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  stream_byte = '0;
	logic        end_of_stream = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [1:0]  error_code;

	http_chunked_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.size_limit_we(size_limit_we),
		.size_limit_wdata(size_limit_wdata),
		.push(push),
		.full(full),
		.stream_byte(stream_byte),
		.end_of_stream(end_of_stream),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.payload_byte(payload_byte),
		.error_code(error_code)
	);

	// Predicted decoder state.
	phase_t          dec_phase;
	logic [31:0]     dec_limit;
	logic [31:0]     dec_size_acc;
	logic [31:0]     dec_remaining;
	longint unsigned dec_offset;
	bit              dec_saw_digit;
	bit              dec_pending_cr;
	bit              dec_trailer_empty;

	res_t        decoded_results[$];
	logic [7:0]  frame_q[$];

	int    send_idle_pct = 0;
	int    pop_stall_pct = 0;
	int    n_items = 0;
	int    n_results = 0;
	int    n_payload = 0;
	int    n_limit_writes = 0;
	int    n_failures = 0;
	int    n_cycles = 0;
	string ending_name = "nothing";

	initial forever #4 clk = ~clk;

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > RUN_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, RUN_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		pop <= ($urandom_range(99) >= pop_stall_pct);

	always @(posedge clk) begin : check_result
		res_t got;
		res_t want;
		if (arst_n && pop && !empty) begin
			got = '{kind, payload_byte, error_code};
			n_results++;
			if (got.kind == KIND_PAYLOAD)
				n_payload++;
			if (decoded_results.size() == 0) begin
				if (n_failures < MAX_REPORTS)
					$display("%0t: unexpected result: kind %0d byte %02h code %0d",
						$time, got.kind, got.payload_byte, got.error_code);
				n_failures++;
			end else begin
				want = decoded_results.pop_front();
				if (got !== want) begin
					if (n_failures < MAX_REPORTS)
						$display({"%0t: mismatch: expected kind %0d byte %02h code %0d,",
							" got kind %0d byte %02h code %0d"}, $time,
							want.kind, want.payload_byte, want.error_code,
							got.kind, got.payload_byte, got.error_code);
					n_failures++;
				end
			end
		end
	end

	function automatic void reset_decoder();
		dec_phase = PH_SIZE;
		dec_limit = RESET_LIMIT;
		dec_size_acc = '0;
		dec_remaining = '0;
		dec_offset = 0;
		dec_saw_digit = 1'b0;
		dec_pending_cr = 1'b0;
		dec_trailer_empty = 1'b1;
	endfunction

	function automatic void post_result(logic [1:0] k, logic [7:0] b, logic [1:0] code);
		res_t r;
		r = '{k, b, code};
		decoded_results.push_back(r);
	endfunction

	function automatic void enter_error(logic [1:0] code);
		dec_phase = PH_ERROR;
		post_result(KIND_ERROR, 8'h00, code);
	endfunction

	// Returns 16 for anything that is not a hex digit.
	function automatic logic [4:0] hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9")
			return 5'(c - "0");
		if (c >= "a" && c <= "f")
			return 5'(c - "a" + 8'd10);
		if (c >= "A" && c <= "F")
			return 5'(c - "A" + 8'd10);
		return 5'd16;
	endfunction

	// True when this byte is the LF of a CR LF pair.
	function automatic bit line_done(logic [7:0] c);
		if (c == CH_LF && dec_pending_cr) begin
			dec_pending_cr = 1'b0;
			return 1'b1;
		end
		dec_pending_cr = (c == CH_CR);
		return 1'b0;
	endfunction

	function automatic void close_size_line();
		dec_pending_cr = 1'b0;
		if (!dec_saw_digit) begin
			enter_error(ERR_BAD_SIZE);
			return;
		end
		if (dec_size_acc == 0) begin
			dec_phase = PH_TRAILER;
			dec_trailer_empty = 1'b1;
			return;
		end
		if (dec_offset + 64'(dec_size_acc) + 2 > 64'(dec_limit)) begin
			enter_error(ERR_TOO_LARGE);
			return;
		end
		dec_remaining = dec_size_acc;
		dec_phase = PH_DATA;
	endfunction

	function automatic void decode_item(logic [7:0] c, logic eos);
		logic [4:0]      nib;
		longint unsigned grown;
		if (dec_phase == PH_DONE || dec_phase == PH_ERROR)
			return;
		if (eos) begin
			enter_error(ERR_TRUNCATED);
			return;
		end
		// The offset limit is checked before the byte is looked at.
		dec_offset++;
		if (dec_offset > 64'(dec_limit)) begin
			enter_error(ERR_TOO_LARGE);
			return;
		end
		case (dec_phase)
			PH_SIZE: begin
				if (dec_pending_cr) begin
					if (c == CH_LF)
						close_size_line();
					else begin
						dec_phase = PH_BAD;
						dec_pending_cr = (c == CH_CR);
					end
				end else if (c == CH_CR)
					dec_pending_cr = 1'b1;
				else if (c == CH_SEMI)
					dec_phase = PH_EXT;
				else begin
					nib = hex_nibble(c);
					grown = 64'(dec_size_acc) * 16 + 64'(nib);
					if (nib[4] || grown > 64'(dec_limit))
						dec_phase = PH_BAD;
					else begin
						dec_size_acc = grown[31:0];
						dec_saw_digit = 1'b1;
					end
				end
			end
			PH_EXT: begin
				if (line_done(c))
					close_size_line();
			end
			PH_BAD: begin
				if (line_done(c))
					enter_error(ERR_BAD_SIZE);
			end
			PH_DATA: begin
				dec_remaining--;
				if (dec_remaining == 0)
					dec_phase = PH_END1;
				post_result(KIND_PAYLOAD, c, 2'd0);
			end
			PH_END1: dec_phase = (c == CH_CR) ? PH_END2 : PH_END2_BAD;
			PH_END2: begin
				if (c != CH_LF)
					enter_error(ERR_BAD_ENDING);
				else begin
					dec_phase = PH_SIZE;
					dec_size_acc = '0;
					dec_saw_digit = 1'b0;
					dec_pending_cr = 1'b0;
				end
			end
			PH_END2_BAD: enter_error(ERR_BAD_ENDING);
			PH_TRAILER: begin
				if (c == CH_LF && dec_pending_cr) begin
					dec_pending_cr = 1'b0;
					if (dec_trailer_empty) begin
						dec_phase = PH_DONE;
						post_result(KIND_COMPLETE, 8'h00, 2'd0);
					end else
						dec_trailer_empty = 1'b1;
				end else begin
					if (dec_pending_cr)
						dec_trailer_empty = 1'b0;
					if (c == CH_CR)
						dec_pending_cr = 1'b1;
					else begin
						dec_pending_cr = 1'b0;
						dec_trailer_empty = 1'b0;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void add_line_end();
		frame_q.push_back(CH_CR);
		frame_q.push_back(CH_LF);
	endfunction

	// Line content with stray CRs but never a CR LF pair.
	function automatic void add_text(int len);
		logic [7:0] b;
		repeat (len) begin
			b = ($urandom_range(7) == 0) ? CH_CR : 8'($urandom_range(255));
			if (b == CH_LF && frame_q.size() != 0 && frame_q[$] == CH_CR)
				b = 8'h20;
			frame_q.push_back(b);
		end
	endfunction

	function automatic void add_data(int len);
		repeat (len)
			frame_q.push_back(8'($urandom_range(255)));
	endfunction

	// A negative ext_len leaves out the extension.
	function automatic void add_size_line(int unsigned value, int zeros, int ext_len);
		int         digits;
		logic [3:0] nib;
		digits = 1;
		while (digits < 8 && (value >> (4 * digits)) != 0)
			digits++;
		repeat (zeros)
			frame_q.push_back("0");
		for (int i = digits - 1; i >= 0; i--) begin
			nib = 4'(value >> (4 * i));
			if (nib < 10)
				frame_q.push_back(8'("0" + nib));
			else
				frame_q.push_back(8'(($urandom_range(1) ? "A" : "a") + nib - 10));
		end
		if (ext_len >= 0) begin
			frame_q.push_back(CH_SEMI);
			add_text(ext_len);
		end
		add_line_end();
	endfunction

	function automatic void add_chunk(int unsigned len);
		int zeros;
		int ext_len;
		zeros = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
		ext_len = ($urandom_range(9) < 3) ? $urandom_range(0, 6) : -1;
		add_size_line(len, zeros, ext_len);
		add_data(len);
		add_line_end();
	endfunction

	function automatic void add_trailer();
		repeat ($urandom_range(2)) begin
			add_text($urandom_range(1, 8));
			add_line_end();
		end
		add_line_end();
	endfunction

	task automatic send_item(logic [7:0] c, logic eos);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		stream_byte <= c;
		end_of_stream <= eos;
		do @(posedge clk); while (full);
		decode_item(c, eos);
		n_items++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			send_item(frame_q[i], 1'b0);
		frame_q.delete();
	endtask

	task automatic send_close();
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	// Waits for all predicted results, then lets in-flight bytes that cause none settle.
	task automatic go_idle();
		push <= 1'b0;
		do @(posedge clk); while (decoded_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [31:0] value);
		go_idle();
		size_limit_we <= 1'b1;
		size_limit_wdata <= value;
		@(posedge clk);
		size_limit_we <= 1'b0;
		dec_limit = value;
		n_limit_writes++;
	endtask

	// Smallest chunks, leading zeros, empty extension and an extension holding a lone CR.
	task automatic test_directed_framing();
		add_size_line(1, 0, -1);
		frame_q.push_back(8'h00);
		add_line_end();
		add_size_line(2, 1, -1);
		frame_q.delete(frame_q.size() - 1);
		frame_q.delete(frame_q.size() - 1);
		frame_q.push_back(CH_SEMI);
		frame_q.push_back(CH_CR);
		frame_q.push_back("x");
		add_line_end();
		frame_q.push_back(8'hFF);
		frame_q.push_back(CH_CR);
		add_line_end();
		add_size_line(1, 0, 0);
		frame_q.push_back(CH_LF);
		add_line_end();
		send_frame();
	endtask

	task automatic test_random_stream(int idle_pct, int stall_pct, logic [31:0] limit,
		int n_bytes);
		int start;
		int pick;
		write_limit(limit);
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		start = n_items;
		while (n_items - start < n_bytes) begin
			pick = $urandom_range(99);
			if (pick < 70)
				add_chunk($urandom_range(1, 8));
			else if (pick < 95)
				add_chunk($urandom_range(9, 40));
			else
				add_chunk($urandom_range(41, 300));
			send_frame();
		end
	endtask

	// Every ending leaves the decoder finished or in its error state for the rest of the run.
	task automatic test_stream_ending();
		logic [7:0] b;
		int         len;
		case ($urandom_range(9))
			0: begin
				ending_name = "completion after trailer lines";
				add_chunk($urandom_range(1, 6));
				add_size_line(0, $urandom_range(2), ($urandom_range(1) != 0) ? 3 : -1);
				add_trailer();
				send_frame();
			end
			1: begin
				ending_name = "a non-hex size character";
				if ($urandom_range(1) != 0)
					frame_q.push_back("1");
				do b = 8'($urandom_range(255));
				while (hex_nibble(b) < 16 || b == CH_CR || b == CH_SEMI);
				frame_q.push_back(b);
				add_text($urandom_range(4));
				add_line_end();
				send_frame();
			end
			2: begin
				ending_name = "a lone CR in a size line";
				frame_q.push_back("1");
				frame_q.push_back(CH_CR);
				frame_q.push_back("x");
				add_line_end();
				send_frame();
			end
			3: begin
				ending_name = "a size value above the limit";
				repeat (9)
					frame_q.push_back("1");
				add_line_end();
				send_frame();
			end
			4: begin
				ending_name = "a size line without digits";
				if ($urandom_range(1) != 0) begin
					frame_q.push_back(CH_SEMI);
					add_text(3);
				end
				add_line_end();
				send_frame();
			end
			5: begin
				ending_name = "a bad chunk ending";
				len = $urandom_range(1, 5);
				add_size_line(len, 0, -1);
				add_data(len);
				if ($urandom_range(1) != 0) begin
					do b = 8'($urandom_range(255)); while (b == CH_CR);
					frame_q.push_back(b);
					frame_q.push_back(CH_LF);
				end else begin
					frame_q.push_back(CH_CR);
					do b = 8'($urandom_range(255)); while (b == CH_LF);
					frame_q.push_back(b);
				end
				send_frame();
			end
			6: begin
				ending_name = "a chunk that runs past the limit";
				write_limit(32'(dec_offset) + 32'd40);
				add_chunk(48);
				send_frame();
			end
			7: begin
				ending_name = "the body offset passing the limit";
				write_limit(32'(dec_offset) + 32'($urandom_range(4)));
				add_chunk(5);
				send_frame();
			end
			8: begin
				ending_name = "truncation inside a framed stream";
				add_chunk($urandom_range(1, 6));
				add_size_line(0, 0, -1);
				add_trailer();
				len = $urandom_range(0, frame_q.size() - 1);
				while (frame_q.size() > len)
					void'(frame_q.pop_back());
				send_frame();
				send_close();
			end
			default: begin
				ending_name = "truncation inside a bad size line";
				frame_q.push_back("z");
				add_text(2);
				send_frame();
				send_close();
			end
		endcase
	endtask

	task automatic test_ignored_after_end();
		write_limit(32'd0);
		repeat (30)
			send_item(8'($urandom_range(255)), $urandom_range(3) == 0);
		write_limit(32'hFFFF_FFFF);
		repeat (10)
			send_item(8'($urandom_range(255)), $urandom_range(1) == 0);
	endtask

	initial begin : run_tests
		int waited;
		reset_decoder();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_framing();
		test_random_stream(0, 0, 32'hFFFF_FFFF, 400);
		test_random_stream(58, 0, 32'(dec_offset) + 32'($urandom_range(50000, 1 << 20)), 400);
		test_random_stream(0, 58, 32'(dec_offset) + 32'($urandom_range(2000, 40000)), 400);
		test_random_stream(19, 19, RESET_LIMIT, 400);
		test_stream_ending();
		test_ignored_after_end();

		push <= 1'b0;
		waited = 0;
		while (decoded_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (decoded_results.size() != 0) begin
			$display("%0t: %0d predicted results never arrived", $time,
				decoded_results.size());
			n_failures++;
		end

		$display("Sent %0d stream items, checked %0d results (%0d payload bytes), %0d limit writes.",
			n_items, n_results, n_payload, n_limit_writes);
		$display("Idling mixes: none, sender, receiver, both; the stream ended with %s.",
			ending_name);
		if (n_failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
sv/hcd_pkg.sv
sv/hcd_queue.sv
sv/hcd_front.sv
sv/hcd_back.sv
sv/http_chunked_decoder.sv
tb/http_chunked_decoder_test.sv
